// ===== design/ppbb_pkg.sv =====
// Shared constants and types for the ping-pong byte buffer.
package ppbb_pkg;

  localparam int BANK_DEPTH = 16;
  localparam int ADDR_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int CNT_W      = $clog2(BANK_DEPTH + 1);
  localparam int SUM_W      = CNT_W + 1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SUM_W-1:0]  sum_t;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_END   = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  // Ring increment of a bank position.
  function automatic addr_t ring_next(input addr_t pos);
    addr_t res;
    if (pos == addr_t'(BANK_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = pos + addr_t'(1);
    end
    return res;
  endfunction

  // Ring position at an offset of fewer than BANK_DEPTH entries from head.
  function automatic addr_t ring_pos(input addr_t head, input cnt_t offset);
    sum_t s;
    s = sum_t'(head) + sum_t'(offset);
    if (s >= sum_t'(BANK_DEPTH)) begin
      s = s - sum_t'(BANK_DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

endpackage

// ===== design/ping_pong_byte_buffer.sv =====
// Two-bank ping-pong byte buffer with a registered result channel.
//
// Usage: every input transaction on the in_ channel carries an operation in
// in_tuser (write byte, read request or end-of-stream marker) and the byte to
// store in in_tdata. Each input transaction produces exactly one result
// transaction on the out_ channel. The result reports the byte read (with its
// valid flag in out_tuser), whether a write was stored, whether a bank is free
// for writing and whether the stream has fully drained after an end marker.
// The bank state is updated, the bank read data is captured and the result
// is registered at the edge that accepts the input transaction; the result
// is offered in the cycle after. Throughput is one transaction per clock
// while the receiver takes each result; the single output register lets a
// new input be taken in the same cycle that the waiting result leaves.
// When the receiver stalls, the result register holds and in_tready drops
// until the result is taken, so no transaction is lost or repeated.
// Reset (synchronous, active low) empties both banks, marks them free, points
// writing and reading at bank zero and clears the end marker. Bank contents
// are not cleared; only bytes written earlier are ever read back.
module ping_pong_byte_buffer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_in
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] read_data, [8] write_accepted,
                                  // [9] write_ready, [10] drained, rest zero
  output logic        out_tuser   // [0] read_valid
);
  import ppbb_pkg::*;

  // Bank storage.
  logic [7:0] bank_zero_r [BANK_DEPTH];
  logic [7:0] bank_one_r  [BANK_DEPTH];

  // Control state.
  cnt_t  count_zero_r, count_zero_nxt;
  cnt_t  count_one_r,  count_one_nxt;
  addr_t head_zero_r,  head_zero_nxt;
  addr_t head_one_r,   head_one_nxt;
  logic  zero_free_r,  zero_free_nxt;
  logic  one_free_r,   one_free_nxt;
  logic  write_to_zero_r, write_to_zero_nxt;
  logic  read_from_zero_r, read_from_zero_nxt;
  logic  end_seen_r,   end_seen_nxt;

  // Result register.
  logic       out_valid_r;
  logic       rd_valid_r;
  logic       rd_zero_r;
  logic [7:0] rd_zero_data_r;
  logic [7:0] rd_one_data_r;
  logic       wr_acc_r;
  logic       wr_ready_r;
  logic       drained_r;

  // Per-transaction decode.
  kind_t kind;
  logic  in_acc;
  logic  wr_zero, wr_one;
  logic  rd_zero, rd_one;
  logic  zero_free_tmp, one_free_tmp;
  addr_t wr_addr_zero, wr_addr_one;

  assign kind      = kind_t'(in_tuser);
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign wr_addr_zero = ring_pos(head_zero_r, count_zero_r);
  assign wr_addr_one  = ring_pos(head_one_r, count_one_r);

  always_comb begin
    count_zero_nxt     = count_zero_r;
    count_one_nxt      = count_one_r;
    head_zero_nxt      = head_zero_r;
    head_one_nxt       = head_one_r;
    zero_free_nxt      = zero_free_r;
    one_free_nxt       = one_free_r;
    write_to_zero_nxt  = write_to_zero_r;
    read_from_zero_nxt = read_from_zero_r;
    end_seen_nxt       = end_seen_r;
    wr_zero            = 1'b0;
    wr_one             = 1'b0;
    rd_zero            = 1'b0;
    rd_one             = 1'b0;
    zero_free_tmp      = zero_free_r;
    one_free_tmp       = one_free_r;

    unique case (kind)
      KIND_WRITE: begin
        if (write_to_zero_r && zero_free_r && count_zero_r < cnt_t'(BANK_DEPTH)) begin
          wr_zero        = 1'b1;
          count_zero_nxt = count_zero_r + cnt_t'(1);
          if (count_zero_nxt == cnt_t'(BANK_DEPTH)) begin
            write_to_zero_nxt = 1'b0;
            zero_free_nxt     = 1'b0;
          end
        end else if (!write_to_zero_r && one_free_r &&
                     count_one_r < cnt_t'(BANK_DEPTH)) begin
          wr_one        = 1'b1;
          count_one_nxt = count_one_r + cnt_t'(1);
          if (count_one_nxt == cnt_t'(BANK_DEPTH)) begin
            write_to_zero_nxt = 1'b1;
            one_free_nxt      = 1'b0;
          end
        end
      end
      KIND_READ: begin
        // After the end marker a partly filled bank is handed to the reader.
        if (end_seen_r && count_zero_r != '0) begin
          zero_free_tmp = 1'b0;
        end
        zero_free_nxt = zero_free_tmp;
        if (read_from_zero_r && !zero_free_tmp && count_zero_r != '0) begin
          rd_zero        = 1'b1;
          count_zero_nxt = count_zero_r - cnt_t'(1);
          head_zero_nxt  = ring_next(head_zero_r);
          if (count_zero_nxt == '0) begin
            zero_free_nxt      = 1'b1;
            read_from_zero_nxt = 1'b0;
          end
        end else begin
          if (end_seen_r && count_one_r != '0) begin
            one_free_tmp = 1'b0;
          end
          one_free_nxt = one_free_tmp;
          if (!read_from_zero_r && !one_free_tmp && count_one_r != '0) begin
            rd_one        = 1'b1;
            count_one_nxt = count_one_r - cnt_t'(1);
            head_one_nxt  = ring_next(head_one_r);
            if (count_one_nxt == '0) begin
              one_free_nxt       = 1'b1;
              read_from_zero_nxt = 1'b1;
            end
          end
        end
      end
      KIND_END: begin
        end_seen_nxt = 1'b1;
      end
      KIND_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_zero_r     <= '0;
      count_one_r      <= '0;
      head_zero_r      <= '0;
      head_one_r       <= '0;
      zero_free_r      <= 1'b1;
      one_free_r       <= 1'b1;
      write_to_zero_r  <= 1'b1;
      read_from_zero_r <= 1'b1;
      end_seen_r       <= 1'b0;
    end else if (in_acc) begin
      count_zero_r     <= count_zero_nxt;
      count_one_r      <= count_one_nxt;
      head_zero_r      <= head_zero_nxt;
      head_one_r       <= head_one_nxt;
      zero_free_r      <= zero_free_nxt;
      one_free_r       <= one_free_nxt;
      write_to_zero_r  <= write_to_zero_nxt;
      read_from_zero_r <= read_from_zero_nxt;
      end_seen_r       <= end_seen_nxt;
    end
  end

  // Bank memories: one write port and one registered read port each.
  always_ff @(posedge clk) begin
    if (in_acc && wr_zero) begin
      bank_zero_r[wr_addr_zero] <= in_tdata;
    end
    if (in_acc) begin
      rd_zero_data_r <= bank_zero_r[head_zero_r];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && wr_one) begin
      bank_one_r[wr_addr_one] <= in_tdata;
    end
    if (in_acc) begin
      rd_one_data_r <= bank_one_r[head_one_r];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_valid_r <= rd_zero || rd_one;
      rd_zero_r  <= rd_zero;
      wr_acc_r   <= wr_zero || wr_one;
      wr_ready_r <= zero_free_nxt || one_free_nxt;
      drained_r  <= end_seen_nxt && count_zero_nxt == '0 && count_one_nxt == '0;
    end
  end

  logic [7:0] read_data;

  always_comb begin
    if (!rd_valid_r) begin
      read_data = 8'd0;
    end else if (rd_zero_r) begin
      read_data = rd_zero_data_r;
    end else begin
      read_data = rd_one_data_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = rd_valid_r;
  assign out_tdata  = {5'd0, drained_r, wr_ready_r, wr_acc_r, read_data};

endmodule
